// ===== src/binary_to_decimal_ascii_emitter_core_defines.svh =====
// Assertion macros shared by the binary to decimal emitter RTL.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef BINARY_TO_DECIMAL_ASCII_EMITTER_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_EMITTER_CORE_DEFINES_SVH

// same-cycle implication
`define B2D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B2D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/b2d_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII emitter.
// No dependencies.
package b2d_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 6;
	localparam int OUT_TDATA_W    = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

	// per-cell control, one op per cycle
	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift_out;
	} b2d_ctrl_t;

endpackage

// ===== src/b2d_cell.sv =====
// One decimal digit cell of the shift-add-3 chain; also shifts digits out.
// Depends on b2d_pkg.
module b2d_cell (
	input  logic                          clk,
	input  b2d_pkg::b2d_ctrl_t            ctrl,
	input  logic                          bit_in,
	input  logic [b2d_pkg::DIGIT_W-1:0]   lower_digit,
	output logic                          carry_out,
	output logic [b2d_pkg::DIGIT_W-1:0]   digit
);

	logic [b2d_pkg::DIGIT_W-1:0] digit_q;
	logic [b2d_pkg::DIGIT_W-1:0] adj;

	assign adj = (digit_q >= b2d_pkg::DABBLE_MIN) ? digit_q + b2d_pkg::DABBLE_ADD : digit_q;
	assign carry_out = adj[b2d_pkg::DIGIT_W-1];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[b2d_pkg::DIGIT_W-2:0], bit_in};
		end else if (ctrl.shift_out) begin
			digit_q <= lower_digit;
		end else begin
			digit_q <= digit_q;
		end
	end

endmodule

// ===== src/binary_to_decimal_ascii_emitter_core.sv =====
// Sequence: accept the value, then one shift-add-3 step per value bit through the digit
// chain, then emit one digit position (DIGITS, 10 at 32 bits) at a time, stalling while
// the output is not ready. A new value is accepted only once its last digit is emitted;
// leading zero positions are skipped, unshown.
// Reset: arst_n clears state, counters and the output valid; digits are not reset.
`include "binary_to_decimal_ascii_emitter_core_defines.svh"

module binary_to_decimal_ascii_emitter_core #(
	parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // [VALUE_BITS-1:0] value
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [b2d_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [5:0] digit_char
	output logic                              m_axis_tlast   // last_digit
);

	localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int CNT_W  = $clog2(VALUE_BITS);
	localparam int REM_W  = $clog2(DIGITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]               state_q;
	logic [VALUE_BITS-1:0]    bin_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [REM_W-1:0]         rem_q;
	logic                     started_q;
	logic                     m_valid_q;
	logic [b2d_pkg::CHAR_W-1:0] out_char_q;
	logic                     out_last_q;

	logic [DIGITS-1:0][b2d_pkg::DIGIT_W-1:0] digit;
	logic [DIGITS-1:0]                       carry;
	logic [b2d_pkg::DIGIT_W-1:0]             top;
	b2d_pkg::b2d_ctrl_t                      ctrl;

	logic in_fire, out_free, is_last, skip, emit_fire, conv_done;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign top       = digit[DIGITS-1];
	assign is_last   = (rem_q == REM_W'(1));
	assign skip      = (state_q == ST_EMIT) && (top == '0) && !started_q && !is_last;
	assign emit_fire = (state_q == ST_EMIT) && !skip && out_free;
	assign conv_done = (state_q == ST_CONV) && (cnt_q == CNT_W'(VALUE_BITS - 1));

	assign ctrl.clear     = in_fire;
	assign ctrl.dabble    = (state_q == ST_CONV);
	assign ctrl.shift_out = skip || emit_fire;

	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			b2d_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.bit_in      (bin_q[VALUE_BITS-1]),
				.lower_digit ('0),
				.carry_out   (carry[i]),
				.digit       (digit[i])
			);
		end else begin : g_next
			b2d_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.bit_in      (carry[i-1]),
				.lower_digit (digit[i-1]),
				.carry_out   (carry[i]),
				.digit       (digit[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (conv_done) begin
						state_q   <= ST_EMIT;
						rem_q     <= REM_W'(DIGITS);
						started_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (skip || emit_fire) begin
						rem_q <= rem_q - REM_W'(1);
					end
					if (emit_fire) begin
						started_q <= 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bin_q <= s_axis_tdata[VALUE_BITS-1:0];
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_char_q <= b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(top);
			out_last_q <= is_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(b2d_pkg::OUT_TDATA_W - b2d_pkg::CHAR_W)'(0), out_char_q};
	assign m_axis_tlast  = out_last_q;

	`B2D_ASSERT_NOW(a_top_bcd, state_q == ST_EMIT, top <= 4'd9, "top digit not BCD")
	`B2D_ASSERT_NOW(a_no_overflow, state_q == ST_CONV, !carry[DIGITS-1], "digit chain overflow")
	`B2D_ASSERT_NEXT(a_conv_to_emit, conv_done,
		state_q == ST_EMIT && rem_q == REM_W'(DIGITS) && !started_q, "bad emit start")
	`B2D_ASSERT_NEXT(a_last_ends, emit_fire && is_last,
		state_q == ST_IDLE && m_valid_q && out_last_q, "last digit did not end item")

endmodule
